/* design/rdc_pkg.sv */
// Package: shared constants, types and helpers of the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

    // Field widths of the channel words
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    // Sizing of the conversion
    localparam int VALUE_BITS = 64;
    localparam int MAX_DIGITS = 64;
    localparam int DIGIT_W    = 6;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // Divider: bits retired per cycle and the cycle count per division
    localparam int BITS_PER_CYC = 8;
    localparam int DIV_CYCLES   = (VALUE_BITS + BITS_PER_CYC - 1) / BITS_PER_CYC;
    localparam int PAD_BITS     = DIV_CYCLES * BITS_PER_CYC;
    localparam int DCYC_W       = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Radix limits and character codes
    localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DEC_DIGITS   = DIGIT_W'(10);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  ASCII_UPPER_A = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0]  CHAR_ERROR   = '0;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_LOAD,
        ST_EMIT
    } rdc_state_t;

    // Divider request
    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [RADIX_W-1:0]    divisor;
    } rdc_div_ctrl_t;

    // Divider status
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } rdc_div_stat_t;

    // Digit value to ASCII: 0-9 then A-Z
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W - DIGIT_W){1'b0}}, d};
        if (d < DEC_DIGITS)
            return dx + ASCII_ZERO;
        else
            return dx - {{(CHAR_W - DIGIT_W){1'b0}}, DEC_DIGITS} + ASCII_UPPER_A;
    endfunction

endpackage

/* design/rdc_in_if.sv */
// Interface: input channel carrying the value and radix word.
`timescale 1ns / 1ps

interface rdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::VALUE_W-1:0] value;
    logic [rdc_pkg::RADIX_W-1:0] radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

/* design/rdc_out_if.sv */
// Interface: output channel carrying one character word.
`timescale 1ns / 1ps

interface rdc_out_if;
    logic                       valid;
    logic                       ready;
    logic [rdc_pkg::CHAR_W-1:0] char_code;
    logic                       last;
    logic                       bad_radix;

    modport source (output valid, output char_code, output last, output bad_radix,
                    input ready);
    modport sink   (input valid, input char_code, input last, input bad_radix,
                    output ready);
endinterface

/* design/rdc_div_unit.sv */
// Iterative divider: divides the running quotient by the radix, 8 bits per cycle.
`timescale 1ns / 1ps

module rdc_div_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rdc_pkg::rdc_div_ctrl_t           ctrl,
    output rdc_pkg::rdc_div_stat_t           stat,
    output logic [rdc_pkg::VALUE_BITS-1:0]   quotient
);

    // Shift register: dividend bits leave at the top, quotient bits enter at the bottom
    logic [rdc_pkg::PAD_BITS-1:0] acc_reg, acc_next;
    logic [rdc_pkg::DIGIT_W-1:0]  rem_reg, rem_next;
    logic [rdc_pkg::RADIX_W-1:0]  dsr_reg, dsr_next;
    logic [rdc_pkg::DCYC_W-1:0]   cyc_reg, cyc_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    // Restoring division step, unrolled over one byte of dividend
    logic [rdc_pkg::BITS_PER_CYC-1:0] qbits;
    logic [rdc_pkg::DIGIT_W-1:0]      rem_step;

    always_comb
    begin
        logic [rdc_pkg::DIGIT_W:0] part;
        rem_step = rem_reg;
        qbits    = '0;
        for (int i = 0; i < rdc_pkg::BITS_PER_CYC; i++)
        begin
            part = {rem_step, acc_reg[rdc_pkg::PAD_BITS-1-i]};
            if (part >= {1'b0, dsr_reg})
            begin
                part = part - {1'b0, dsr_reg};
                qbits[rdc_pkg::BITS_PER_CYC-1-i] = 1'b1;
            end
            rem_step = part[rdc_pkg::DIGIT_W-1:0];
        end
    end

    // Sequencing of one division
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cyc_next  = cyc_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            acc_next  = rdc_pkg::PAD_BITS'(ctrl.dividend);
            rem_next  = '0;
            dsr_next  = ctrl.divisor;
            cyc_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << rdc_pkg::BITS_PER_CYC)
                     | rdc_pkg::PAD_BITS'(qbits);
            rem_next = rem_step;
            cyc_next = cyc_reg + 1'b1;
            if (cyc_reg == rdc_pkg::DCYC_W'(rdc_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cyc_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cyc_reg  <= cyc_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy      = busy_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;
    assign quotient       = acc_reg[rdc_pkg::VALUE_BITS-1:0];

endmodule

/* design/rdc_digit_store.sv */
// Digit store: one write port, one registered read port.
`timescale 1ns / 1ps

module rdc_digit_store
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [rdc_pkg::IDX_W-1:0]     wr_addr,
    input  logic [rdc_pkg::DIGIT_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [rdc_pkg::IDX_W-1:0]     rd_addr,
    output logic [rdc_pkg::DIGIT_W-1:0]   rd_data
);

    logic [rdc_pkg::DIGIT_W-1:0] mem_reg [rdc_pkg::MAX_DIGITS];
    logic [rdc_pkg::DIGIT_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/radix_digit_converter.sv */
// Radix digit converter: unsigned value to ASCII digits in base 2 to 36.
// A bad radix word is valid the cycle after acceptance. Otherwise each digit takes
// 8 divider steps of 8 quotient bits and one step to store it and restart, repeated
// until the quotient is zero; each character then takes a store read, a load and
// the handshake, most significant first. No new number is accepted until the last
// character of the current one has been taken.
// Reset (rst_n, async, active low) returns to idle; the digit store is not cleared.
`timescale 1ns / 1ps

module radix_digit_converter
(
    input  logic      clk,
    input  logic      rst_n,
    rdc_in_if.sink    number,
    rdc_out_if.source text
);

    rdc_pkg::rdc_state_t state_reg, state_next;

    logic [rdc_pkg::CNT_W-1:0]   n_reg, n_next;
    logic [rdc_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [rdc_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rdc_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;
    logic                        bad_reg, bad_next;

    rdc_pkg::rdc_div_ctrl_t        div_ctrl;
    rdc_pkg::rdc_div_stat_t        div_stat;
    logic [rdc_pkg::VALUE_BITS-1:0] div_quot;

    logic                        wr_en;
    logic                        rd_en;
    logic [rdc_pkg::DIGIT_W-1:0] rd_data;
    logic                        in_fire;
    logic                        out_fire;
    logic                        radix_ok;
    logic [rdc_pkg::CNT_W-1:0]   n_fin;

    // Single divider, reused for every digit
    rdc_div_unit u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Remainders, least significant first
    rdc_digit_store u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (n_reg[rdc_pkg::IDX_W-1:0]),
        .wr_data (div_stat.remainder),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign in_fire  = number.valid && number.ready;
    assign out_fire = out_valid_reg && text.ready;
    assign radix_ok = (number.radix >= rdc_pkg::RADIX_MIN)
                   && (number.radix <= rdc_pkg::RADIX_MAX);

    // Next state and outputs
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        radix_next     = radix_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        number.ready   = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        n_fin          = n_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.dividend = div_quot;
        div_ctrl.divisor  = radix_reg;

        case (state_reg)
            rdc_pkg::ST_IDLE:
            begin
                number.ready      = 1'b1;
                div_ctrl.dividend = number.value[rdc_pkg::VALUE_BITS-1:0];
                div_ctrl.divisor  = number.radix;
                if (in_fire)
                begin
                    if (radix_ok)
                    begin
                        div_ctrl.start = 1'b1;
                        radix_next     = number.radix;
                        n_next         = '0;
                        state_next     = rdc_pkg::ST_DIVIDE;
                    end
                    else
                    begin
                        n_next         = '0;
                        char_next      = rdc_pkg::CHAR_ERROR;
                        last_next      = 1'b1;
                        bad_next       = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = rdc_pkg::ST_EMIT;
                    end
                end
            end

            rdc_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    // Keep the low digits once the store is full
                    if (n_reg < rdc_pkg::CNT_W'(rdc_pkg::MAX_DIGITS))
                    begin
                        wr_en = 1'b1;
                        n_fin = n_reg + 1'b1;
                    end
                    n_next = n_fin;
                    if (div_quot != '0)
                    begin
                        div_ctrl.start = 1'b1;
                    end
                    else
                    begin
                        idx_next   = rdc_pkg::IDX_W'(n_fin - 1'b1);
                        state_next = rdc_pkg::ST_FETCH;
                    end
                end
            end

            rdc_pkg::ST_FETCH:
            begin
                rd_en      = 1'b1;
                state_next = rdc_pkg::ST_LOAD;
            end

            rdc_pkg::ST_LOAD:
            begin
                char_next      = rdc_pkg::digit_to_ascii(rd_data);
                last_next      = (idx_reg == '0);
                bad_next       = 1'b0;
                out_valid_next = 1'b1;
                state_next     = rdc_pkg::ST_EMIT;
            end

            rdc_pkg::ST_EMIT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = rdc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = rdc_pkg::ST_FETCH;
                    end
                end
            end

            default:
            begin
                state_next = rdc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rdc_pkg::ST_IDLE;
            n_reg         <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
    end

    assign text.valid     = out_valid_reg;
    assign text.char_code = char_reg;
    assign text.last      = last_reg;
    assign text.bad_radix = bad_reg;

    // Divider only runs while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> state_reg == rdc_pkg::ST_DIVIDE)
        else $error("divider busy outside divide state");

    // No new number taken while a character word is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        number.ready |-> !text.valid)
        else $error("input ready while output word pending");

    // An error word is the only word of its conversion
    assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.bad_radix) |-> (text.last && text.char_code == rdc_pkg::CHAR_ERROR))
        else $error("bad radix word malformed");

    // A digit count of zero never reaches the read phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rdc_pkg::ST_FETCH) |-> (n_reg != '0))
        else $error("fetch with no digits stored");

endmodule

/* tb/tb.sv */
// Testbench for the radix digit converter: directed and random values against a predictor.
`timescale 1ns / 1ps

module tb;
    import rdc_pkg::*;

    localparam int RANDOM_WORDS  = 196;
    localparam int CALM_WORDS    = 60;        // random words sent with no idling
    localparam int HOLD_AT_WORD  = 110;       // receiver stalls once this many words are in
    localparam int HOLD_CYCLES   = 800;
    localparam int DRAIN_AT      = 170;       // sender waits for all text here
    localparam int TAIL_CYCLES   = 800;
    localparam int CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last;
        logic              bad_radix;
    } char_word_t;

    // One directed row; text is typed in where it is obvious, else the predictor runs
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        bit                 bad;
        string              text;
    } row_t;

    logic clk;
    logic rst_n;

    rdc_in_if  in_ch ();
    rdc_out_if out_ch ();

    radix_digit_converter dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (in_ch),
        .text   (out_ch)
    );

    char_word_t expected_chars[$];
    int         errors      = 0;
    int         chars_seen  = 0;
    int         words_in    = 0;
    int         bad_words   = 0;
    int         cycles      = 0;
    bit         no_idle     = 1'b0;
    bit         hold_done   = 1'b0;

    row_t rows[24] = '{
        '{64'd0,                  6'd10, 1'b0, "0"},
        '{64'd0,                  6'd2,  1'b0, "0"},
        '{64'd0,                  6'd36, 1'b0, "0"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b0, "FFFFFFFFFFFFFFFF"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd2,  1'b0, ""},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 1'b0, "18446744073709551615"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 1'b0, ""},
        '{64'd35,                 6'd36, 1'b0, "Z"},
        '{64'd9,                  6'd10, 1'b0, "9"},
        '{64'd10,                 6'd36, 1'b0, "A"},
        '{64'd255,                6'd16, 1'b0, "FF"},
        '{64'd1,                  6'd2,  1'b0, "1"},
        '{64'd2,                  6'd2,  1'b0, "10"},
        '{64'd123,                6'd0,  1'b1, ""},
        '{64'd1,                  6'd1,  1'b1, ""},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd37, 1'b1, ""},
        '{64'd5,                  6'd63, 1'b1, ""},
        '{64'h8000_0000_0000_0000, 6'd2,  1'b0, ""},
        '{64'd1234567890,         6'd10, 1'b0, "1234567890"},
        '{64'h0123_4567_89AB_CDEF, 6'd16, 1'b0, "123456789ABCDEF"},
        '{64'd36,                 6'd36, 1'b0, "10"},
        '{64'hFFFF_FFFF_FFFF_FFFF, 6'd3,  1'b0, ""},
        '{64'hAAAA_AAAA_AAAA_AAAA, 6'd7,  1'b0, ""},
        '{64'h5555_5555_5555_5555, 6'd35, 1'b0, ""}
    };

    // Clock: 12 ns period
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d characters still due",
                     cycles, expected_chars.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Predictor: repeated division, remainders sent most significant first
    function automatic void convert_to_chars(input logic [VALUE_W-1:0] value,
                                             input logic [RADIX_W-1:0] radix);
        logic [VALUE_W-1:0] q;
        logic [VALUE_W-1:0] base;
        logic [5:0]         digits[MAX_DIGITS];
        logic [5:0]         d;
        char_word_t         w;
        int                 n;
        if (radix < RADIX_MIN || radix > RADIX_MAX)
        begin
            w.char_code = CHAR_ERROR;
            w.last      = 1'b1;
            w.bad_radix = 1'b1;
            expected_chars.push_back(w);
            return;
        end
        base = VALUE_W'(radix);
        q    = value;
        n    = 0;
        do
        begin
            if (n < MAX_DIGITS)
            begin
                digits[n] = 6'(q % base);
                n++;
            end
            q = q / base;
        end
        while (q != 0);
        for (int k = n - 1; k >= 0; k--)
        begin
            d = digits[k];
            w.char_code = (d < 6'd10) ? ASCII_ZERO + CHAR_W'(d)
                                      : ASCII_UPPER_A + CHAR_W'(d) - CHAR_W'(10);
            w.last      = (k == 0);
            w.bad_radix = 1'b0;
            expected_chars.push_back(w);
        end
    endfunction

    // Literal expectation of a directed row
    function automatic void expect_literal(input bit bad, input string text);
        char_word_t w;
        if (bad)
        begin
            w.char_code = CHAR_ERROR;
            w.last      = 1'b1;
            w.bad_radix = 1'b1;
            expected_chars.push_back(w);
            return;
        end
        for (int i = 0; i < text.len(); i++)
        begin
            w.char_code = CHAR_W'(text[i]);
            w.last      = (i == text.len() - 1);
            w.bad_radix = 1'b0;
            expected_chars.push_back(w);
        end
    endfunction

    // Offer one word after a random gap, none while no_idle is set; returns at the accepting edge
    task automatic offer_word(input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= value;
        in_ch.radix <= radix;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_in++;
        if (radix < RADIX_MIN || radix > RADIX_MAX)
            bad_words++;
    endtask

    // Let every outstanding character arrive
    task automatic drain_text();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Random value of random length; radix mostly legal with extremes favored
    task automatic random_word(output logic [VALUE_W-1:0] value,
                               output logic [RADIX_W-1:0] radix);
        int nbits;
        int pick;
        value = {$urandom, $urandom};
        if ($urandom_range(0, 7) != 0)
        begin
            nbits = $urandom_range(1, VALUE_W);
            if (nbits < VALUE_W)
                value = value & ((64'd1 << nbits) - 64'd1);
        end
        pick = $urandom_range(0, 19);
        if (pick < 2)
            radix = ($urandom_range(0, 1) != 0) ? RADIX_W'($urandom_range(0, 1))
                                                : RADIX_W'($urandom_range(37, 63));
        else if (pick < 7)
            case ($urandom_range(0, 3))
                0: radix = RADIX_MIN;
                1: radix = RADIX_W'(10);
                2: radix = RADIX_W'(16);
                default: radix = RADIX_MAX;
            endcase
        else
            radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endtask

    // Stimulus and end of run
    initial
    begin
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        in_ch.radix = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (rows[i])
        begin
            offer_word(rows[i].value, rows[i].radix);
            if (rows[i].bad || rows[i].text.len() != 0)
                expect_literal(rows[i].bad, rows[i].text);
            else
                convert_to_chars(rows[i].value, rows[i].radix);
        end
        drain_text();

        // Random words: a calm stretch first, then random gaps on both sides
        no_idle = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == CALM_WORDS)
                no_idle = 1'b0;
            if (i == DRAIN_AT)
                drain_text();
            random_word(value, radix);
            offer_word(value, radix);
            convert_to_chars(value, radix);
        end
        drain_text();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Converted %0d words (%0d with a bad radix) into %0d checked characters",
                 words_in, bad_words, chars_seen);
        $display("Bases 0 to 63, values up to 64 bits, with idle gaps and a long output stall");
        if (errors == 0 && expected_chars.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && words_in >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 15);
                repeat (stall)
                begin
                    out_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // Check each accepted character word against the oldest expectation
    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            chars_seen++;
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word char=%h last=%b bad=%b", $time,
                         out_ch.char_code, out_ch.last, out_ch.bad_radix);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_ch.char_code !== want.char_code)
                begin
                    errors++;
                    $display("%0t: char_code expected %h actual %h", $time,
                             want.char_code, out_ch.char_code);
                end
                if (out_ch.last !== want.last)
                begin
                    errors++;
                    $display("%0t: last expected %b actual %b", $time,
                             want.last, out_ch.last);
                end
                if (out_ch.bad_radix !== want.bad_radix)
                begin
                    errors++;
                    $display("%0t: bad_radix expected %b actual %b", $time,
                             want.bad_radix, out_ch.bad_radix);
                end
            end
        end
    end

endmodule

/* sim.f */
design/rdc_pkg.sv
design/rdc_in_if.sv
design/rdc_out_if.sv
design/rdc_div_unit.sv
design/rdc_digit_store.sv
design/radix_digit_converter.sv
tb/tb.sv
